[hw/rtl/cbt_pkg.sv]
// Shared types and constants of the cubic Bezier tessellator.
// Used by the front end, the command queue, the back end and the top level.
// No dependencies.
package cbt_pkg;

    // Input kinds carried in tuser
    typedef enum logic [1:0] {
        FUNC_LOAD = 2'd0,
        FUNC_TESS = 2'd1,
        FUNC_EVAL = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    // Work kinds handed from the front end to the back end
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_POINTS = 2'd1,
        OP_ERROR  = 2'd2,
        OP_SPARE  = 2'd3
    } op_t;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FEW_NODES = 2'd1;
    localparam logic [1:0] ST_BAD_SEG   = 2'd2;

    // Handle kinds within a node
    localparam logic [1:0] HK_CENTER = 2'd0;
    localparam logic [1:0] HK_LEFT   = 2'd1;
    localparam logic [1:0] HK_RIGHT  = 2'd2;

    // Register indexes of the APB port
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic REG_RESOLUTION = 1'b1;

    // Field widths
    localparam int NC_W    = 5;
    localparam int RES_W   = 6;
    localparam int T_W     = 17;
    localparam int SEGF_W  = 8;
    localparam int COORD_W = 32;
    localparam int IN_W    = 64;
    localparam int OUT_W   = 96;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [T_W-1:0] ONE_Q16 = 17'h10000;

    // Input tdata layout
    localparam int F_NODE_LO  = 0;
    localparam int F_KIND_LO  = 4;
    localparam int F_AXIS_LO  = 6;
    localparam int F_COORD_LO = 8;
    localparam int F_SEG_LO   = 40;
    localparam int F_POS_LO   = 44;

    // One queued command
    typedef struct packed {
        op_t                op;
        logic [3:0]         node;
        logic [1:0]         kind;
        logic [1:0]         axis;
        logic [COORD_W-1:0] value;
        logic [SEGF_W-1:0]  seg;
        logic [T_W-1:0]     t;
        logic               tess;
        logic [RES_W-1:0]   res;
        logic [RES_W-1:0]   steps;
        logic [1:0]         status;
    } cmd_t;

endpackage

[hw/rtl/cbt_front.sv]
// Front end: takes input requests, checks them against the configuration
// and turns them into queued commands. Depends on cbt_pkg.
module cbt_front #(
    parameter int MAX_NODES      = 16,
    parameter int MAX_RESOLUTION = 63
) (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [cbt_pkg::IN_W-1:0]     s_tdata,
    input  logic [1:0]                   s_tuser,
    input  logic [cbt_pkg::NC_W-1:0]     node_count,
    input  logic [cbt_pkg::RES_W-1:0]    resolution,
    input  logic                         queue_full,
    output logic                         push,
    output cbt_pkg::cmd_t                cmd
);

    logic [3:0]                   node_index;
    logic [1:0]                   handle_kind;
    logic [1:0]                   axis;
    logic [cbt_pkg::COORD_W-1:0]  coordinate;
    logic [3:0]                   segment_index;
    logic [cbt_pkg::T_W-1:0]      curve_position;
    logic [8:0]                   nc9;
    logic [8:0]                   n9;
    logic [cbt_pkg::SEGF_W-1:0]   segs;
    logic [cbt_pkg::SEGF_W-1:0]   seg_in;
    logic [cbt_pkg::RES_W-1:0]    res;
    logic [cbt_pkg::T_W-1:0]      t_clamp;
    logic [cbt_pkg::T_W+cbt_pkg::SEGF_W-1:0] prod;
    logic                         load_ok;

    // Field unpacking
    assign node_index     = s_tdata[cbt_pkg::F_NODE_LO +: 4];
    assign handle_kind    = s_tdata[cbt_pkg::F_KIND_LO +: 2];
    assign axis           = s_tdata[cbt_pkg::F_AXIS_LO +: 2];
    assign coordinate     = s_tdata[cbt_pkg::F_COORD_LO +: cbt_pkg::COORD_W];
    assign segment_index  = s_tdata[cbt_pkg::F_SEG_LO +: 4];
    assign curve_position = s_tdata[cbt_pkg::F_POS_LO +: cbt_pkg::T_W];

    assign s_tready = !queue_full;

    // Active nodes and segments
    assign nc9    = 9'(node_count);
    assign n9     = (nc9 > 9'(MAX_NODES)) ? 9'(MAX_NODES) : nc9;
    assign segs   = (n9 >= 9'd2) ? cbt_pkg::SEGF_W'(n9 - 9'd1) : '0;
    assign seg_in = cbt_pkg::SEGF_W'(segment_index);

    // Resolution clamp
    always_comb
    begin
        res = resolution;
        if (resolution == '0)
            res = cbt_pkg::RES_W'(1);
        else if (7'(resolution) > 7'(MAX_RESOLUTION))
            res = cbt_pkg::RES_W'(MAX_RESOLUTION);
    end

    // Global position to segment and local t
    assign t_clamp = (curve_position > cbt_pkg::ONE_Q16) ? cbt_pkg::ONE_Q16 : curve_position;
    assign prod    = t_clamp * segs;

    assign load_ok = (9'(node_index) < 9'(MAX_NODES)) && (handle_kind <= cbt_pkg::HK_RIGHT)
                     && (axis <= 2'd2);

    // Classification
    always_comb
    begin
        cmd        = '0;
        cmd.op     = cbt_pkg::OP_LOAD;
        cmd.node   = node_index;
        cmd.kind   = handle_kind;
        cmd.axis   = axis;
        cmd.value  = coordinate;
        cmd.res    = res;
        cmd.status = cbt_pkg::ST_OK;
        push       = 1'b0;
        case (cbt_pkg::func_t'(s_tuser))
            cbt_pkg::FUNC_LOAD:
            begin
                push = s_tvalid && s_tready && load_ok;
            end
            cbt_pkg::FUNC_TESS:
            begin
                push     = s_tvalid && s_tready;
                cmd.tess = 1'b1;
                cmd.seg  = seg_in;
                if (segs == '0)
                begin
                    cmd.op     = cbt_pkg::OP_ERROR;
                    cmd.status = cbt_pkg::ST_FEW_NODES;
                end
                else if (seg_in >= segs)
                begin
                    cmd.op     = cbt_pkg::OP_ERROR;
                    cmd.status = cbt_pkg::ST_BAD_SEG;
                end
                else
                begin
                    cmd.op    = cbt_pkg::OP_POINTS;
                    cmd.steps = (seg_in == segs - 8'd1) ? res : res - cbt_pkg::RES_W'(1);
                end
            end
            cbt_pkg::FUNC_EVAL:
            begin
                push = s_tvalid && s_tready;
                if (segs == '0)
                begin
                    cmd.op     = cbt_pkg::OP_ERROR;
                    cmd.status = cbt_pkg::ST_FEW_NODES;
                end
                else if (t_clamp == cbt_pkg::ONE_Q16)
                begin
                    cmd.op  = cbt_pkg::OP_POINTS;
                    cmd.seg = segs - 8'd1;
                    cmd.t   = cbt_pkg::ONE_Q16;
                end
                else
                begin
                    cmd.op  = cbt_pkg::OP_POINTS;
                    cmd.seg = prod[16 +: cbt_pkg::SEGF_W];
                    cmd.t   = {1'b0, prod[15:0]};
                end
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/cbt_cmd_queue.sv]
// Short command queue between the front end and the back end.
// Depends on cbt_pkg.
module cbt_cmd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  cbt_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output cbt_pkg::cmd_t cmd_out,
    output logic          empty
);

    cbt_pkg::cmd_t entry_reg [cbt_pkg::QUEUE_DEPTH];
    logic          wr_ptr_reg;
    logic          wr_ptr_next;
    logic          rd_ptr_reg;
    logic          rd_ptr_next;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;

    assign full    = (count_reg == 2'(cbt_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == 2'd0);
    assign cmd_out = entry_reg[rd_ptr_reg];

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

[hw/rtl/cbt_back.sv]
// Back end: handle memory, step divider, shared lerp unit and output register.
// Depends on cbt_pkg.
module cbt_back #(
    parameter int MAX_NODES   = 16,
    parameter int COORD_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cbt_pkg::cmd_t             cmd_in,
    input  logic                      queue_empty,
    output logic                      pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [cbt_pkg::OUT_W-1:0] m_tdata,
    output logic                      m_tlast,
    output logic [1:0]                m_tuser
);

    localparam int CW    = COORD_WIDTH;
    localparam int MW    = CW + 1;
    localparam int PW    = MW + cbt_pkg::T_W;
    localparam int DEPTH = MAX_NODES * 9;
    localparam int AW    = $clog2(DEPTH);
    localparam int SEG_W = $clog2(MAX_NODES);
    localparam int XW    = (CW > 32) ? CW : 32;

    localparam logic signed [XW-1:0] CW_HI = XW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [XW-1:0] CW_LO = ~CW_HI;
    localparam logic signed [XW-1:0] O_HI  = XW'(32'sh7FFFFFFF);
    localparam logic signed [XW-1:0] O_LO  = ~O_HI;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_DIV  = 7'b0000010,
        S_READ = 7'b0000100,
        S_DIFF = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_ADD  = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    cbt_pkg::cmd_t               cmd_reg;
    logic signed [CW-1:0]        mem [DEPTH];
    logic signed [CW-1:0]        rd_data_reg;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic signed [CW-1:0]        wr_value;
    logic signed [XW-1:0]        in_ext;

    logic [cbt_pkg::T_W-1:0]     t_reg;
    logic [cbt_pkg::T_W-1:0]     base_reg;
    logic [cbt_pkg::RES_W-1:0]   remb_reg;
    logic [cbt_pkg::RES_W:0]     acc_rem_reg;
    logic [4:0]                  div_cnt_reg;
    logic [cbt_pkg::RES_W:0]     div_rem_reg;
    logic [cbt_pkg::T_W-1:0]     div_q_reg;
    logic [cbt_pkg::RES_W-1:0]   step_reg;
    logic [1:0]                  axis_reg;
    logic [2:0]                  rd_cnt_reg;
    logic [1:0]                  lvl_reg;
    logic [1:0]                  j_reg;
    logic signed [CW-1:0]        w_reg [4];
    logic signed [CW-1:0]        a_reg;
    logic [MW-1:0]               m_reg;
    logic                        neg_reg;
    logic [PW-1:0]               prod_reg;
    logic signed [CW-1:0]        pt_reg [3];

    logic                        out_valid_reg;
    logic [cbt_pkg::OUT_W-1:0]   out_data_reg;
    logic                        out_last_reg;
    logic [1:0]                  out_user_reg;

    logic [SEG_W-1:0]            seg;
    logic [SEG_W-1:0]            rd_node;
    logic [1:0]                  rd_kind;
    logic [cbt_pkg::RES_W:0]     div_trial;
    logic                        div_bit;
    logic                        div_ge;
    logic [cbt_pkg::RES_W:0]     div_rem_new;
    logic [cbt_pkg::T_W-1:0]     div_q_new;
    logic [cbt_pkg::RES_W:0]     acc_sum;
    logic signed [MW-1:0]        diff;
    logic [PW-1:0]               r_full;
    logic signed [MW:0]          a_ext;
    logic signed [MW:0]          r_ext;
    logic signed [MW:0]          lerp_sum;
    logic signed [CW-1:0]        lerp_res;
    logic                        out_free;
    logic                        last_out;
    logic                        item_done;
    logic [1:0]                  rd_idx;

    assign seg      = cmd_reg.seg[SEG_W-1:0];
    assign out_free = !out_valid_reg || m_tready;
    assign pop      = (state_reg == S_IDLE) && !queue_empty;
    assign last_out = (cmd_reg.op == cbt_pkg::OP_ERROR) || !cmd_reg.tess
                      || (step_reg == cmd_reg.steps);
    assign item_done = last_out;

    // Memory addresses: node*9 + kind*3 + axis
    always_comb
    begin
        rd_node = (rd_cnt_reg < 3'd2) ? seg : seg + SEG_W'(1);
        case (rd_cnt_reg)
            3'd0:    rd_kind = cbt_pkg::HK_CENTER;
            3'd1:    rd_kind = cbt_pkg::HK_RIGHT;
            3'd2:    rd_kind = cbt_pkg::HK_LEFT;
            default: rd_kind = cbt_pkg::HK_CENTER;
        endcase
        rd_addr = (AW'(rd_node) << 3) + AW'(rd_node) + AW'(rd_kind) + (AW'(rd_kind) << 1)
                  + AW'(axis_reg);
        wr_addr = (AW'(cmd_in.node) << 3) + AW'(cmd_in.node) + AW'(cmd_in.kind)
                  + (AW'(cmd_in.kind) << 1) + AW'(cmd_in.axis);
    end

    // Load value saturated to the stored width
    always_comb
    begin
        in_ext = XW'($signed(cmd_in.value));
        if (in_ext > CW_HI)
            wr_value = CW'(CW_HI);
        else if (in_ext < CW_LO)
            wr_value = CW'(CW_LO);
        else
            wr_value = CW'(in_ext);
    end

    // Handle memory
    always_ff @(posedge clk)
    begin
        if (pop && cmd_in.op == cbt_pkg::OP_LOAD)
            mem[wr_addr] <= wr_value;
        rd_data_reg <= mem[rd_addr];
    end

    // Divider step, step accumulator and lerp datapath
    assign div_bit     = (div_cnt_reg == 5'd16);
    assign div_trial   = {div_rem_reg[cbt_pkg::RES_W-1:0], div_bit};
    assign div_ge      = (div_trial >= (cbt_pkg::RES_W+1)'(cmd_reg.res));
    assign div_rem_new = div_ge ? div_trial - (cbt_pkg::RES_W+1)'(cmd_reg.res) : div_trial;
    assign div_q_new   = {div_q_reg[cbt_pkg::T_W-2:0], div_ge};
    assign acc_sum     = acc_rem_reg + (cbt_pkg::RES_W+1)'(remb_reg);
    assign diff        = MW'(w_reg[j_reg + 2'd1]) - MW'(w_reg[j_reg]);
    assign r_full      = (prod_reg + PW'(32768)) >> 16;
    assign a_ext       = (MW+1)'(a_reg);
    assign r_ext       = $signed({1'b0, r_full[MW-1:0]});
    assign lerp_sum    = neg_reg ? a_ext - r_ext : a_ext + r_ext;
    assign lerp_res    = CW'(lerp_sum);
    assign rd_idx      = 2'(rd_cnt_reg - 3'd1);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    case (cmd_in.op)
                        cbt_pkg::OP_ERROR:  state_next = S_EMIT;
                        cbt_pkg::OP_POINTS: state_next = cmd_in.tess ? S_DIV : S_READ;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_cnt_reg == 5'd0)
                    state_next = S_READ;
            end
            S_READ:
            begin
                if (rd_cnt_reg == 3'd4)
                    state_next = S_DIFF;
            end
            S_DIFF: state_next = S_MUL;
            S_MUL:  state_next = S_ADD;
            S_ADD:
            begin
                if (j_reg == 2'd2 - lvl_reg)
                begin
                    if (lvl_reg == 2'd2)
                        state_next = (axis_reg == 2'd2) ? S_EMIT : S_READ;
                    else
                        state_next = S_DIFF;
                end
                else
                    state_next = S_DIFF;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = item_done ? S_IDLE : S_READ;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EMIT && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    cmd_reg     <= cmd_in;
                    t_reg       <= cmd_in.t;
                    step_reg    <= '0;
                    axis_reg    <= 2'd0;
                    rd_cnt_reg  <= 3'd0;
                    div_cnt_reg <= 5'd16;
                    div_rem_reg <= '0;
                    div_q_reg   <= '0;
                end
            end
            S_DIV:
            begin
                // One quotient bit of 65536 / resolution per cycle
                div_rem_reg <= div_rem_new;
                div_q_reg   <= div_q_new;
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd0)
                begin
                    base_reg    <= div_q_new;
                    remb_reg    <= cbt_pkg::RES_W'(div_rem_new);
                    t_reg       <= '0;
                    acc_rem_reg <= (cbt_pkg::RES_W+1)'(cmd_reg.res >> 1);
                end
            end
            S_READ:
            begin
                if (rd_cnt_reg != 3'd0)
                    w_reg[rd_idx] <= rd_data_reg;
                rd_cnt_reg <= rd_cnt_reg + 3'd1;
                lvl_reg    <= 2'd0;
                j_reg      <= 2'd0;
            end
            S_DIFF:
            begin
                a_reg   <= w_reg[j_reg];
                neg_reg <= diff[MW-1];
                m_reg   <= diff[MW-1] ? MW'(-diff) : MW'(diff);
            end
            S_MUL:
            begin
                prod_reg <= m_reg * t_reg;
            end
            S_ADD:
            begin
                w_reg[j_reg] <= lerp_res;
                if (j_reg == 2'd2 - lvl_reg)
                begin
                    j_reg <= 2'd0;
                    if (lvl_reg == 2'd2)
                    begin
                        pt_reg[axis_reg] <= lerp_res;
                        axis_reg         <= axis_reg + 2'd1;
                        rd_cnt_reg       <= 3'd0;
                    end
                    else
                        lvl_reg <= lvl_reg + 2'd1;
                end
                else
                    j_reg <= j_reg + 2'd1;
            end
            S_EMIT:
            begin
                if (out_free && !item_done)
                begin
                    // Next step parameter: t += 65536/R with remainder carry
                    step_reg   <= step_reg + cbt_pkg::RES_W'(1);
                    axis_reg   <= 2'd0;
                    rd_cnt_reg <= 3'd0;
                    if (acc_sum >= (cbt_pkg::RES_W+1)'(cmd_reg.res))
                    begin
                        acc_rem_reg <= acc_sum - (cbt_pkg::RES_W+1)'(cmd_reg.res);
                        t_reg       <= t_reg + base_reg + cbt_pkg::T_W'(1);
                    end
                    else
                    begin
                        acc_rem_reg <= acc_sum;
                        t_reg       <= t_reg + base_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Output register
    function automatic logic [31:0] sat_out(input logic signed [CW-1:0] v);
        logic signed [XW-1:0] e;
        e = XW'(v);
        if (e > O_HI)
            return 32'(O_HI);
        else if (e < O_LO)
            return 32'(O_LO);
        else
            return 32'(e);
    endfunction

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EMIT && out_free)
        begin
            out_last_reg <= last_out;
            out_user_reg <= cmd_reg.status;
            if (cmd_reg.op == cbt_pkg::OP_ERROR)
                out_data_reg <= '0;
            else
                out_data_reg <= {sat_out(pt_reg[2]), sat_out(pt_reg[1]), sat_out(pt_reg[0])};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

[hw/rtl/cubic_bezier_tessellator.sv]
// Top level of the cubic Bezier tessellator: APB registers, front end,
// command queue and back end. Depends on cbt_pkg, cbt_front, cbt_cmd_queue, cbt_back.
//
//  channel  | direction | carries
//  ---------+-----------+--------------------------------------------------
//  s_*      | in        | requests: load handle, tessellate, evaluate
//  m_*      | out       | points x/y/z, tlast on last point, status in tuser
//  APB      | in/out    | node_count (0x0), resolution (0x4)
//
// Per axis, a point takes four handle memory reads (one read port) and six lerps,
// each passing the diff, multiply and add steps on one shared multiplier.
// A tessellate request first runs the bit-serial step divider. A load is
// written as the back end pops it, without leaving idle. Reset clears control state only; the
// handle memory holds nothing defined until written. A stalled output holds
// the back end in its emit step; the two-entry queue keeps accepting meanwhile.
module cubic_bezier_tessellator #(
    parameter int MAX_NODES      = 16,
    parameter int COORD_WIDTH    = 32,
    parameter int MAX_RESOLUTION = 63
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // node_index[3:0], handle_kind[5:4], axis[7:6], coordinate[39:8],
    // segment_index[43:40], curve_position[60:44], zero[63:61]
    input  logic [63:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // point_x[31:0], point_y[63:32], point_z[95:64]
    output logic [95:0] m_tdata,
    // last_point
    output logic        m_tlast,
    // status[1:0]
    output logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [cbt_pkg::NC_W-1:0]  node_count_reg;
    logic [cbt_pkg::RES_W-1:0] resolution_reg;
    logic                      cfg_wr;
    logic                      push;
    logic                      pop;
    logic                      full;
    logic                      empty;
    cbt_pkg::cmd_t             cmd_push;
    cbt_pkg::cmd_t             cmd_pop;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= '0;
            resolution_reg <= cbt_pkg::RES_W'(16);
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                cbt_pkg::REG_NODE_COUNT: node_count_reg <= pwdata[cbt_pkg::NC_W-1:0];
                cbt_pkg::REG_RESOLUTION: resolution_reg <= pwdata[cbt_pkg::RES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            cbt_pkg::REG_NODE_COUNT: prdata = 32'(node_count_reg);
            cbt_pkg::REG_RESOLUTION: prdata = 32'(resolution_reg);
            default:                 prdata = '0;
        endcase
    end

    cbt_front #(
        .MAX_NODES      (MAX_NODES),
        .MAX_RESOLUTION (MAX_RESOLUTION)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .node_count (node_count_reg),
        .resolution (resolution_reg),
        .queue_full (full),
        .push       (push),
        .cmd        (cmd_push)
    );

    cbt_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .cmd_in  (cmd_push),
        .full    (full),
        .pop     (pop),
        .cmd_out (cmd_pop),
        .empty   (empty)
    );

    cbt_back #(
        .MAX_NODES   (MAX_NODES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_in      (cmd_pop),
        .queue_empty (empty),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

endmodule

[hw/rtl/cbt_checker.sv]
// Port-level checks of the cubic Bezier tessellator, bound to the top level.
// Depends on cubic_bezier_tessellator.
module cbt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata,
    input logic        m_tlast,
    input logic [1:0]  m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // Error results carry a zero point and close the request
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != cbt_pkg::ST_OK |-> m_tdata == 96'd0 && m_tlast)
        else $error("error result not zero or not last");

    // node_count reads back what was written
    a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && paddr == 3'd0
        |=> paddr != 3'd0 || prdata == 32'($past(pwdata[4:0])))
        else $error("node_count read-back mismatch");

endmodule

bind cubic_bezier_tessellator cbt_checker u_cbt_checker (.*);

[tb/tb.sv]
// Self-checking testbench of cubic_bezier_tessellator: random and directed requests,
// a scoreboard with a bit-accurate point predictor and random idling on both streams.
// Depends on cbt_pkg and the cubic_bezier_tessellator RTL.
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_CYCLES = 20000;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
        logic [1:0]  status;
    } point_t;

    // Scoreboard: mirror of the handle table and registers, queue of due points
    class curve_scoreboard;
        longint      handles [16][3][3];
        int unsigned node_count;
        int unsigned resolution;
        point_t      due_points [$];
        int          errors;

        function new();
            node_count = 0;
            resolution = 16;
            errors     = 0;
        endfunction

        function void add_due(point_t p);
            due_points.insert(due_points.size(), p);
        endfunction

        function longint lerp_q16(longint a, longint b, longint unsigned t);
            longint          d;
            longint unsigned m;
            longint unsigned r;
            d = b - a;
            m = (d < 0) ? longint'(-d) : longint'(d);
            r = (m >> 16) * t + (((m & 64'hFFFF) * t + 64'h8000) >> 16);
            return (d < 0) ? a - longint'(r) : a + longint'(r);
        endfunction

        function logic [31:0] clip32(longint v);
            if (v > 64'sd2147483647)
                return 32'h7FFF_FFFF;
            if (v < -64'sd2147483648)
                return 32'h8000_0000;
            return v[31:0];
        endfunction

        // de Casteljau on one segment, per axis
        function point_t curve_point(int unsigned seg, longint unsigned t, logic last);
            point_t p;
            longint c [3];
            longint q0, q1, q2, r0, r1;
            for (int a = 0; a < 3; a++)
            begin
                q0 = lerp_q16(handles[seg][cbt_pkg::HK_CENTER][a],
                              handles[seg][cbt_pkg::HK_RIGHT][a], t);
                q1 = lerp_q16(handles[seg][cbt_pkg::HK_RIGHT][a],
                              handles[seg+1][cbt_pkg::HK_LEFT][a], t);
                q2 = lerp_q16(handles[seg+1][cbt_pkg::HK_LEFT][a],
                              handles[seg+1][cbt_pkg::HK_CENTER][a], t);
                r0 = lerp_q16(q0, q1, t);
                r1 = lerp_q16(q1, q2, t);
                c[a] = lerp_q16(r0, r1, t);
            end
            p.x = clip32(c[0]);
            p.y = clip32(c[1]);
            p.z = clip32(c[2]);
            p.last = last;
            p.status = cbt_pkg::ST_OK;
            return p;
        endfunction

        function void push_error(logic [1:0] st);
            point_t p;
            p.x = '0;
            p.y = '0;
            p.z = '0;
            p.last = 1'b1;
            p.status = st;
            add_due(p);
        endfunction

        function void note_request(logic [1:0] fn, logic [63:0] d);
            int unsigned     nodes, segs, seg, res, steps;
            logic [1:0]      kind, axis;
            longint unsigned t, prod;
            nodes = (node_count > 16) ? 16 : node_count;
            segs  = (nodes >= 2) ? nodes - 1 : 0;
            case (cbt_pkg::func_t'(fn))
                cbt_pkg::FUNC_LOAD:
                begin
                    kind = d[cbt_pkg::F_KIND_LO +: 2];
                    axis = d[cbt_pkg::F_AXIS_LO +: 2];
                    if (kind <= 2 && axis <= 2)
                        handles[d[cbt_pkg::F_NODE_LO +: 4]][kind][axis] =
                            longint'($signed(d[cbt_pkg::F_COORD_LO +: 32]));
                end
                cbt_pkg::FUNC_TESS:
                begin
                    seg = d[cbt_pkg::F_SEG_LO +: 4];
                    if (segs == 0)
                        push_error(cbt_pkg::ST_FEW_NODES);
                    else if (seg >= segs)
                        push_error(cbt_pkg::ST_BAD_SEG);
                    else
                    begin
                        res = (resolution < 1) ? 1 : (resolution > 63) ? 63 : resolution;
                        steps = (seg == segs - 1) ? res : res - 1;
                        for (int unsigned s = 0; s <= steps; s++)
                        begin
                            t = (longint'(s) * 65536 + res / 2) / res;
                            add_due(curve_point(seg, t, s == steps));
                        end
                    end
                end
                cbt_pkg::FUNC_EVAL:
                begin
                    t = d[cbt_pkg::F_POS_LO +: 17];
                    if (segs == 0)
                        push_error(cbt_pkg::ST_FEW_NODES);
                    else
                    begin
                        if (t >= 65536)
                        begin
                            seg = segs - 1;
                            t   = 65536;
                        end
                        else
                        begin
                            prod = t * segs;
                            seg  = prod >> 16;
                            t    = prod & 64'hFFFF;
                        end
                        add_due(curve_point(seg, t, 1'b1));
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_point(logic [95:0] d, logic last, logic [1:0] st);
            point_t e;
            if (due_points.size() == 0)
            begin
                $display("%0t: unexpected point %h last %b status %0d", $time, d, last, st);
                errors++;
                return;
            end
            e = due_points.pop_front();
            if (d[31:0] !== e.x)
            begin
                $display("%0t: x expected %h got %h", $time, e.x, d[31:0]);
                errors++;
            end
            if (d[63:32] !== e.y)
            begin
                $display("%0t: y expected %h got %h", $time, e.y, d[63:32]);
                errors++;
            end
            if (d[95:64] !== e.z)
            begin
                $display("%0t: z expected %h got %h", $time, e.z, d[95:64]);
                errors++;
            end
            if (last !== e.last)
            begin
                $display("%0t: last expected %b got %b", $time, e.last, last);
                errors++;
            end
            if (st !== e.status)
            begin
                $display("%0t: status expected %0d got %0d", $time, e.status, st);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic        m_tlast;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    curve_scoreboard board;
    logic            calm;
    int              quiet_cycles;

    cubic_bezier_tessellator dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Output side back-pressure
    always @(posedge clk)
        m_tready <= calm || ($urandom_range(99) >= 17);

    // Monitor: predict on accepted requests, check accepted points
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.note_request(s_tuser, s_tdata);
            if (m_tvalid && m_tready)
                board.check_point(m_tdata, m_tlast, m_tuser);
        end
    end

    // Watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_CYCLES)
        begin
            $display("cubic_bezier_tessellator verification failed");
            $finish;
        end
    end

    function automatic logic [63:0] pack_req(logic [3:0] node, logic [1:0] kind,
                                             logic [1:0] axis, logic [31:0] coord,
                                             logic [3:0] seg, logic [16:0] pos);
        logic [63:0] d;
        d = '0;
        d[cbt_pkg::F_NODE_LO +: 4]   = node;
        d[cbt_pkg::F_KIND_LO +: 2]   = kind;
        d[cbt_pkg::F_AXIS_LO +: 2]   = axis;
        d[cbt_pkg::F_COORD_LO +: 32] = coord;
        d[cbt_pkg::F_SEG_LO +: 4]    = seg;
        d[cbt_pkg::F_POS_LO +: 17]   = pos;
        return d;
    endfunction

    task automatic send_req(cbt_pkg::func_t fn, logic [63:0] d);
        while (!calm && $urandom_range(99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic apb_write(logic regsel, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {regsel, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (regsel == cbt_pkg::REG_NODE_COUNT)
            board.node_count = v[4:0];
        else
            board.resolution = v[5:0];
    endtask

    // Drain all due points, then let trailing loads retire
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.due_points.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic load_coord(logic [3:0] node, logic [1:0] kind, logic [1:0] axis,
                              logic [31:0] v);
        send_req(cbt_pkg::FUNC_LOAD,
                 pack_req(node, kind, axis, v, 4'($urandom), 17'($urandom)));
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return '0;
            3, 4, 5: return $urandom;
            default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
        endcase
    endfunction

    function automatic logic [16:0] pick_position();
        case ($urandom_range(9))
            0: return 17'h10000;
            1: return 17'h1FFFF;
            2: return '0;
            3: return 17'h10000 + $urandom_range(17'hFFFF);
            default: return $urandom_range(17'hFFFF);
        endcase
    endfunction

    int unsigned phase_nodes [6] = '{2, 16, 31, 5, 9, 3};
    int unsigned phase_res   [6] = '{1, 63, 0, 40, 4, 7};

    initial
    begin
        board    = new();
        calm     = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = cbt_pkg::FUNC_LOAD;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fewer than two nodes, and the unused function code
        send_req(cbt_pkg::FUNC_TESS, pack_req(0, 0, 0, 0, 0, 0));
        send_req(cbt_pkg::FUNC_EVAL, pack_req(0, 0, 0, 0, 0, 17'h10000));
        send_req(cbt_pkg::FUNC_NONE, pack_req(4'hF, 2'd3, 2'd3, '1, 4'hF, '1));
        settle();
        apb_write(cbt_pkg::REG_NODE_COUNT, 1);
        send_req(cbt_pkg::FUNC_EVAL, pack_req(0, 0, 0, 0, 0, 17'h8000));
        settle();

        // Fill the whole handle table so no unwritten entry is ever read
        for (int n = 0; n < 16; n++)
            for (int k = 0; k < 3; k++)
                for (int a = 0; a < 3; a++)
                    load_coord(4'(n), 2'(k), 2'(a), pick_coord());
        // Ignored loads: handle kind 3, axis 3
        load_coord(4'd3, 2'd3, 2'd1, 32'h1234_5678);
        load_coord(4'd3, 2'd0, 2'd3, 32'h8765_4321);
        settle();

        for (int ph = 0; ph < 6; ph++)
        begin
            apb_write(cbt_pkg::REG_NODE_COUNT, phase_nodes[ph]);
            apb_write(cbt_pkg::REG_RESOLUTION, phase_res[ph]);
            calm = (ph == 3);
            // Directed: first, last and out-of-range segment, edge positions
            send_req(cbt_pkg::FUNC_TESS, pack_req(0, 0, 0, 0, 4'd0, 0));
            send_req(cbt_pkg::FUNC_TESS, pack_req(0, 0, 0, 0, 4'hF, 0));
            send_req(cbt_pkg::FUNC_TESS, pack_req(0, 0, 0, 0, 4'(phase_nodes[ph] - 2), 0));
            send_req(cbt_pkg::FUNC_EVAL, pack_req(0, 0, 0, 0, 0, 17'h0));
            send_req(cbt_pkg::FUNC_EVAL, pack_req(0, 0, 0, 0, 0, 17'h10000));
            send_req(cbt_pkg::FUNC_EVAL, pack_req(0, 0, 0, 0, 0, 17'h1FFFF));
            send_req(cbt_pkg::FUNC_EVAL, pack_req(0, 0, 0, 0, 0, 17'hFFFF));
            // Random mix
            for (int i = 0; i < 20; i++)
            begin
                case ($urandom_range(19))
                    0, 1, 2, 3, 4:
                        load_coord(4'($urandom), 2'($urandom_range(2)),
                                   2'($urandom_range(2)), pick_coord());
                    5:
                        send_req(cbt_pkg::FUNC_NONE, {3'b000, 61'({$urandom, $urandom})});
                    6, 7, 8, 9, 10, 11, 12:
                        send_req(cbt_pkg::FUNC_TESS, pack_req(4'($urandom), 2'($urandom),
                                 2'($urandom), $urandom, 4'($urandom), 17'($urandom)));
                    default:
                        send_req(cbt_pkg::FUNC_EVAL, pack_req(4'($urandom), 2'($urandom),
                                 2'($urandom), $urandom, 4'($urandom), pick_position()));
                endcase
            end
            settle();
        end

        if (board.errors == 0)
            $display("cubic_bezier_tessellator verification clean");
        else
            $display("cubic_bezier_tessellator verification failed");
        $finish;
    end

endmodule
